@@ rtl/core/bm3x3_pkg.sv @@
package bm3x3_pkg;

   localparam int PIX_W = 24;
   localparam int LS_DATA_W = 2 * PIX_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam int MODE_W = 2;

   localparam logic [PIX_W-1:0] WHITE = 24'hFFFFFF;
   localparam logic [PIX_W-1:0] BLACK = 24'h000000;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_ERODE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HOLLOW = 2'd2;

   localparam int FRAME_WIDTH_RESET = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_rgb;
      logic flush;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_rgb;
      logic frame_last;
   } rsp_word_type;

   typedef struct packed {
      logic push;
      logic emit;
      logic border;
      logic last;
   } item_ctrl_type;

   typedef struct packed {
      logic valid;
      item_ctrl_type ctrl;
      logic any_white;
      logic any_black;
      logic [PIX_W-1:0] centre;
   } win_result_type;

   // size minus one, clamped to 3..hi
   function automatic int clamp_m1(int v, int hi);
      int r;
      if (v < 3) begin
         r = 2;
      end else if (v > hi) begin
         r = hi - 1;
      end else begin
         r = v - 1;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/bm3x3_line_store.sv @@
module bm3x3_line_store
   import bm3x3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [LS_DATA_W-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output logic [LS_DATA_W-1:0] rd_data
);

   logic [LS_DATA_W-1:0] mem_ff [MAX_WIDTH];
   logic [LS_DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bm3x3_window.sv @@
module bm3x3_window
   import bm3x3_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  item_ctrl_type in_ctrl,
   input  logic [PIX_W-1:0] col_top,
   input  logic [PIX_W-1:0] col_mid,
   input  logic [PIX_W-1:0] col_bot,
   output win_result_type result
);

   logic [PIX_W-1:0] win_ff [3][3];
   logic s3_valid_ff;
   item_ctrl_type s3_ctrl_ff;
   win_result_type s4_ff;
   logic any_white_in;
   logic any_black_in;

   // shift the window one column on each pushed word
   always_ff @(posedge clock) begin
      if (en && in_valid && in_ctrl.push) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= col_top;
         win_ff[1][2] <= col_mid;
         win_ff[2][2] <= col_bot;
      end
   end

   always_comb begin
      any_white_in = 1'b0;
      any_black_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(r == 1 && c == 1)) begin
               any_white_in = any_white_in | (win_ff[r][c] == WHITE);
               any_black_in = any_black_in | (win_ff[r][c] == BLACK);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= in_valid;
         s4_ff.valid <= s3_valid_ff;
      end
      if (en) begin
         s3_ctrl_ff <= in_ctrl;
         s4_ff.ctrl <= s3_ctrl_ff;
         s4_ff.any_white <= any_white_in;
         s4_ff.any_black <= any_black_in;
         s4_ff.centre <= win_ff[1][1];
      end
   end

   assign result = s4_ff;

endmodule

@@ rtl/core/binary_morphology_3x3_core.sv @@
// 3x3 binary morphology on a raster stream of 24-bit RGB pixels.
// req_* takes one word per pixel (pixel_rgb, flush); rsp_* gives filtered
// pixels in raster order, frame_last set on the final pixel of a frame.
// csr_* writes mode (index 0), frame_width (1) and frame_height (2); it is
// always ready. A size write restarts the frame. Sizes clamp to 3..MAX.
// The result for pixel p is released by the word that carries pixel p+W+1
// (W = line width); after a whole frame is in, each further word (flush or
// pixel) releases one of the last W+1 results. A flush before the frame is
// complete is dropped.
// Throughput is one word per clock while req_stall is low. A released result
// shows on rsp_valid after these registers: two stages for the line store read
// (one MAX_WIDTH x 48 bit memory, one read and one write port), the window
// shift and compare, and one for the mode select and the output register.
// Reset clears the pipeline, counters and registers (mode 0, 640 x 480).
// When rsp_stall is high, a skid register takes one more result and then
// req_stall rises; nothing is lost or repeated.
module binary_morphology_3x3_core
   import bm3x3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_word_type req_word,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_word_type rsp_word,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int INROW_W = $clog2(MAX_HEIGHT + 1);

   logic [MODE_W-1:0] mode_ff;
   logic [COL_W-1:0] wm1_ff;
   logic [ROW_W-1:0] hm1_ff;

   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [INROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   logic en;
   logic accept;
   logic csr_write;
   logic data_phase;
   logic primed;
   item_ctrl_type s0_ctrl;

   logic s1_valid_ff;
   item_ctrl_type s1_ctrl_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_addr_ff;

   logic s2_valid_ff;
   item_ctrl_type s2_ctrl_ff;
   logic [PIX_W-1:0] s2_pix_ff;
   logic [COL_W-1:0] s2_addr_ff;

   logic [LS_DATA_W-1:0] ls_rd_data;
   logic [PIX_W-1:0] row_top;
   logic [PIX_W-1:0] row_mid;

   win_result_type s4;
   rsp_word_type result_in;
   logic q_push;
   logic q_pop;
   logic head_valid_ff;
   rsp_word_type head_ff;
   logic skid_valid_ff;
   rsp_word_type skid_ff;

   assign en = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept = req_valid && en;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ERODE;
         wm1_ff <= COL_W'(clamp_m1(FRAME_WIDTH_RESET, MAX_WIDTH));
         hm1_ff <= ROW_W'(clamp_m1(FRAME_HEIGHT_RESET, MAX_HEIGHT));
      end else if (csr_write) begin
         case (csr_index)
            CSR_MODE: begin
               mode_ff <= csr_wdata[MODE_W-1:0];
            end
            CSR_FRAME_WIDTH: begin
               wm1_ff <= COL_W'(clamp_m1(int'(csr_wdata), MAX_WIDTH));
            end
            CSR_FRAME_HEIGHT: begin
               hm1_ff <= ROW_W'(clamp_m1(int'(csr_wdata), MAX_HEIGHT));
            end
            default: begin
            end
         endcase
      end
   end

   assign data_phase = in_row_ff <= INROW_W'(hm1_ff);
   assign primed = (in_row_ff >= INROW_W'(2)) ||
                   (in_row_ff == INROW_W'(1) && in_col_ff != '0);

   always_comb begin
      s0_ctrl.push = data_phase ? !req_word.flush : 1'b1;
      s0_ctrl.emit = data_phase ? (!req_word.flush && primed) : 1'b1;
      s0_ctrl.border = out_row_ff == '0 || out_row_ff == hm1_ff ||
                       out_col_ff == '0 || out_col_ff == wm1_ff;
      s0_ctrl.last = out_row_ff == hm1_ff && out_col_ff == wm1_ff;
   end

   always_comb begin
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept && s0_ctrl.push) begin
         if (in_col_ff == wm1_ff) begin
            in_col_in = '0;
            if (data_phase) begin
               in_row_in = in_row_ff + INROW_W'(1);
            end
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
      if (accept && s0_ctrl.emit) begin
         if (out_col_ff == wm1_ff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
      // restart at frame end or on a size write
      if ((accept && s0_ctrl.emit && s0_ctrl.last) ||
          (csr_write && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT))) begin
         in_col_in = '0;
         in_row_in = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid && (s0_ctrl.push || s0_ctrl.emit);
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ctrl_ff <= s0_ctrl;
         s1_pix_ff <= req_word.pixel_rgb;
         s1_addr_ff <= in_col_ff;
         s2_ctrl_ff <= s1_ctrl_ff;
         s2_pix_ff <= s1_pix_ff;
         s2_addr_ff <= s1_addr_ff;
      end
   end

   bm3x3_line_store #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_line_store (
      .clock(clock),
      .wr_en(en && s2_valid_ff && s2_ctrl_ff.push),
      .wr_addr(s2_addr_ff),
      .wr_data({row_mid, s2_pix_ff}),
      .rd_en(en),
      .rd_addr(s1_addr_ff),
      .rd_data(ls_rd_data)
   );

   assign row_top = ls_rd_data[LS_DATA_W-1:PIX_W];
   assign row_mid = ls_rd_data[PIX_W-1:0];

   bm3x3_window u_window (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(s2_valid_ff),
      .in_ctrl(s2_ctrl_ff),
      .col_top(row_top),
      .col_mid(row_mid),
      .col_bot(s2_pix_ff),
      .result(s4)
   );

   always_comb begin
      result_in.frame_last = s4.ctrl.last;
      result_in.out_rgb = s4.centre;
      if (!s4.ctrl.border) begin
         case (mode_ff)
            MODE_ERODE: begin
               if (s4.any_white) begin
                  result_in.out_rgb = WHITE;
               end
            end
            MODE_DILATE: begin
               if (s4.any_black) begin
                  result_in.out_rgb = BLACK;
               end
            end
            MODE_HOLLOW: begin
               if (!s4.any_white) begin
                  result_in.out_rgb = WHITE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign q_push = en && s4.valid && s4.ctrl.emit;
   assign q_pop = head_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (q_pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (q_push) begin
         if (head_valid_ff && !q_pop) begin
            skid_valid_ff <= 1'b1;
         end else begin
            head_valid_ff <= 1'b1;
         end
      end else if (q_pop) begin
         head_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (q_pop) begin
            head_ff <= skid_ff;
         end
      end else if (q_push) begin
         if (head_valid_ff && !q_pop) begin
            skid_ff <= result_in;
         end else begin
            head_ff <= result_in;
         end
      end
   end

   assign rsp_valid = head_valid_ff;
   assign rsp_word = head_ff;

endmodule

@@ test/binary_morphology_3x3_core_check.sv @@
`timescale 1ns / 1ps

module binary_morphology_3x3_core_check
   import bm3x3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  req_word_type req_word,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  rsp_word_type rsp_word,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int failures,
   output int pending
);

   localparam int HISTORY_DEPTH = 2 * MAX_WIDTH + 4;

   logic [PIX_W-1:0] history [HISTORY_DEPTH];
   logic [MODE_W-1:0] mode_now;
   logic [CSR_DATA_W-1:0] width_now;
   logic [CSR_DATA_W-1:0] height_now;
   int unsigned next_col;
   int unsigned next_row;
   int unsigned emitted;
   rsp_word_type filtered_q [$];

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [PIX_W-1:0] pixel_at(int unsigned pos);
      return history[pos % HISTORY_DEPTH];
   endfunction

   function automatic bit ring_has(int unsigned p, int unsigned w,
                                   logic [PIX_W-1:0] colour);
      int unsigned dr;
      int unsigned dc;
      bit hit;
      hit = 1'b0;
      for (dr = 0; dr < 3; dr++) begin
         for (dc = 0; dc < 3; dc++) begin
            if (!(dr == 1 && dc == 1) && pixel_at(p - w - 1 + dr * w + dc) == colour) begin
               hit = 1'b1;
            end
         end
      end
      return hit;
   endfunction

   function automatic logic [PIX_W-1:0] filtered_pixel(int unsigned p, int unsigned w,
                                                         int unsigned h);
      int unsigned r;
      int unsigned c;
      logic [PIX_W-1:0] res;
      r = p / w;
      c = p % w;
      res = pixel_at(p);
      if (r != 0 && r != h - 1 && c != 0 && c != w - 1) begin
         case (mode_now)
            MODE_ERODE: begin
               if (ring_has(p, w, WHITE)) res = WHITE;
            end
            MODE_DILATE: begin
               if (ring_has(p, w, BLACK)) res = BLACK;
            end
            MODE_HOLLOW: begin
               if (!ring_has(p, w, WHITE)) res = WHITE;
            end
            default: begin
            end
         endcase
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      int unsigned w;
      int unsigned h;
      int unsigned total;
      int unsigned in_pos;
      int unsigned p;
      bit emit;
      rsp_word_type want;
      if (reset) begin
         mode_now = MODE_ERODE;
         width_now = CSR_DATA_W'(FRAME_WIDTH_RESET);
         height_now = CSR_DATA_W'(FRAME_HEIGHT_RESET);
         next_col = 0;
         next_row = 0;
         emitted = 0;
         filtered_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               failures++;
               $display("%0t unexpected word: expected none, got rgb %h last %b",
                        $time, rsp_word.out_rgb, rsp_word.frame_last);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_word.out_rgb !== want.out_rgb) begin
                  failures++;
                  $display("%0t out_rgb mismatch: expected %h, got %h",
                           $time, want.out_rgb, rsp_word.out_rgb);
               end
               if (rsp_word.frame_last !== want.frame_last) begin
                  failures++;
                  $display("%0t frame_last mismatch: expected %b, got %b",
                           $time, want.frame_last, rsp_word.frame_last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE: mode_now = csr_wdata[MODE_W-1:0];
               CSR_FRAME_WIDTH: begin
                  width_now = csr_wdata;
                  next_col = 0;
                  next_row = 0;
                  emitted = 0;
               end
               CSR_FRAME_HEIGHT: begin
                  height_now = csr_wdata;
                  next_col = 0;
                  next_row = 0;
                  emitted = 0;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            w = clamp_dim(width_now, MAX_WIDTH);
            h = clamp_dim(height_now, MAX_HEIGHT);
            total = w * h;
            in_pos = next_row * w + next_col;
            p = emitted;
            emit = 1'b0;
            if (in_pos < total) begin
               if (!req_word.flush) begin
                  history[in_pos % HISTORY_DEPTH] = req_word.pixel_rgb;
                  next_col++;
                  if (next_col >= w) begin
                     next_col = 0;
                     next_row++;
                  end
                  emit = (p + w + 1 <= in_pos);
               end
            end else begin
               emit = (p < total);
            end
            if (emit) begin
               want.out_rgb = filtered_pixel(p, w, h);
               want.frame_last = (p == total - 1);
               filtered_q.push_back(want);
               emitted = p + 1;
               if (emitted >= total) begin
                  next_col = 0;
                  next_row = 0;
                  emitted = 0;
               end
            end
         end
      end
      pending <= filtered_q.size();
   end

endmodule

@@ test/binary_morphology_3x3_core_test.sv @@
`timescale 1ns / 1ps

module binary_morphology_3x3_core_test;
   import bm3x3_pkg::*;

   localparam int MAX_DIM = 1024;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES = 10;
   localparam logic [MODE_W-1:0] MODE_PASS = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int failures;
   int pending;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic hold_wanted = 1'b0;
   int unsigned frame_w = FRAME_WIDTH_RESET;
   int unsigned frame_h = FRAME_HEIGHT_RESET;
   int unsigned fill = 0;
   int unsigned drained = 0;
   int unsigned cycles = 0;

   logic [PIX_W-1:0] erode_demo [9] = '{WHITE, BLACK, 24'h123456,
                                         24'hFFFFFE, 24'hABCDEF, 24'h000001,
                                         BLACK, 24'hFEFFFF, WHITE};
   logic [PIX_W-1:0] tall_demo [12] = '{BLACK, 24'h112233, WHITE,
                                         24'h445566, 24'h778899, 24'hFFFFFE,
                                         24'h010101, 24'hAAAAAA, 24'hFEFEFE,
                                         24'h808080, BLACK, 24'h7F7F7F};

   logic [MODE_W-1:0] phase_mode [PHASES] = '{MODE_ERODE, MODE_DILATE, MODE_HOLLOW,
                                              MODE_PASS, MODE_DILATE, MODE_ERODE,
                                              MODE_HOLLOW, MODE_DILATE, MODE_HOLLOW,
                                              MODE_PASS};
   int unsigned phase_w [PHASES] = '{4, 5, 3, 6, 0, 0, 2047, 3, 8, 3};
   int unsigned phase_h [PHASES] = '{4, 3, 5, 4, 0, 2, 3, 1500, 6, 3};
   bit phase_resize [PHASES] = '{1, 1, 1, 1, 0, 1, 1, 1, 1, 1};
   int unsigned phase_items [PHASES] = '{140, 140, 140, 100, 80, 80, 1030, 80, 120, 60};
   int unsigned phase_pace [PHASES] = '{0, 1, 2, 3, 1, 2, 3, 0, 2, 1};

   binary_morphology_3x3_core #(
      .MAX_WIDTH(MAX_DIM),
      .MAX_HEIGHT(MAX_DIM)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   binary_morphology_3x3_core_check #(
      .MAX_WIDTH(MAX_DIM),
      .MAX_HEIGHT(MAX_DIM)
   ) u_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .failures(failures),
      .pending(pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : receiver
      int unsigned held;
      bit hold_served;
      hold_served = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_served) begin
            hold_served = 1'b1;
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // track frame position to shape the random stream
      if (fill < frame_w * frame_h) begin
         if (!w.flush) fill++;
      end else begin
         drained++;
         if (drained == frame_w + 1) begin
            fill = 0;
            drained = 0;
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      int unsigned v;
      v = value & 32'h7FF;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index != CSR_MODE) begin
         v = (v < 3) ? 3 : (v > MAX_DIM) ? MAX_DIM : v;
         if (index == CSR_FRAME_WIDTH) frame_w = v;
         else frame_h = v;
         fill = 0;
         drained = 0;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      req_word_type w;
      int unsigned j;
      int unsigned k;
      int unsigned n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_reg(CSR_MODE, MODE_ERODE);
      write_reg(CSR_FRAME_WIDTH, 3);
      write_reg(CSR_FRAME_HEIGHT, 3);
      csr_valid <= 1'b0;
      send_word('{pixel_rgb: WHITE, flush: 1'b1});
      for (j = 0; j < 9; j++) send_word('{pixel_rgb: erode_demo[j], flush: 1'b0});
      send_word('{pixel_rgb: BLACK, flush: 1'b1});
      send_word('{pixel_rgb: 24'h7F7F7F, flush: 1'b0});
      send_word('{pixel_rgb: WHITE, flush: 1'b1});
      send_word('{pixel_rgb: 24'h0F0F0F, flush: 1'b0});

      wait_idle();
      write_reg(CSR_MODE, MODE_DILATE);
      write_reg(CSR_FRAME_HEIGHT, 4);
      csr_valid <= 1'b0;
      for (j = 0; j < 9; j++) send_word('{pixel_rgb: tall_demo[j], flush: 1'b0});
      wait_idle();
      // switch mode mid-frame
      write_reg(CSR_MODE, MODE_HOLLOW);
      csr_valid <= 1'b0;
      for (j = 9; j < 12; j++) send_word('{pixel_rgb: tall_demo[j], flush: 1'b0});
      for (j = 0; j < 4; j++) send_word('{pixel_rgb: PIX_W'($urandom()), flush: 1'b1});

      for (k = 0; k < PHASES; k++) begin
         wait_idle();
         write_reg(CSR_MODE, phase_mode[k]);
         if (phase_resize[k]) begin
            write_reg(CSR_FRAME_WIDTH, phase_w[k]);
            write_reg(CSR_FRAME_HEIGHT, phase_h[k]);
         end
         csr_valid <= 1'b0;
         case (phase_pace[k])
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 55;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 55;
            end
            default: begin
               send_idle_pct = 37;
               recv_stall_pct = 37;
            end
         endcase
         if (k == 0) hold_wanted <= 1'b1;
         for (n = 0; n < phase_items[k]; n++) begin
            // drain the block mid-stream
            if (k == 2 && n == phase_items[k] / 2) wait_idle();
            case ($urandom_range(9))
               0, 1, 2: w.pixel_rgb = WHITE;
               3, 4, 5: w.pixel_rgb = BLACK;
               6: w.pixel_rgb = WHITE ^ (PIX_W'(1) << $urandom_range(PIX_W - 1));
               7: w.pixel_rgb = PIX_W'(1) << $urandom_range(PIX_W - 1);
               default: w.pixel_rgb = PIX_W'($urandom());
            endcase
            if (fill < frame_w * frame_h) w.flush = ($urandom_range(19) == 0);
            else w.flush = ($urandom_range(3) != 0);
            send_word(w);
         end
      end

      wait_idle();
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/bm3x3_pkg.sv
rtl/core/bm3x3_line_store.sv
rtl/core/bm3x3_window.sv
rtl/core/binary_morphology_3x3_core.sv
test/binary_morphology_3x3_core_check.sv
test/binary_morphology_3x3_core_test.sv
